// File: src/lrc_pkg.sv
`default_nettype none
package lrc_pkg;
  localparam int unsigned DEFAULT_ENTRIES = 1024;
  localparam logic [30:0] DEFAULT_BUDGET  = 31'd33554432;
  localparam int unsigned KEY_W   = 42;
  localparam int unsigned LEN_W   = 31;
  localparam int unsigned STAMP_W = 64;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned EVC_W   = 11;
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;
  localparam logic [1:0] KIND_ARCHIVE = 2'd0;
  localparam logic [1:0] KIND_REFTAB  = 2'd1;
  localparam logic [0:0] REG_BUDGET = 1'b0;

  // Build the stored key; reference-table keys keep only kind and table.
  function automatic logic [KEY_W-1:0] make_key(input logic [1:0] kind,
                                                input logic [7:0] tbl,
                                                input logic [23:0] arch,
                                                input logic [7:0] flg);
    logic [KEY_W-1:0] k;
    begin
      if (kind == KIND_REFTAB) k = {kind, tbl, 24'd0, 8'd0};
      else k = {kind, tbl, arch, flg};
      return k;
    end
  endfunction
endpackage
`default_nettype wire

// File: src/lru_response_cache_byte_budget.sv
`default_nettype none
// LRU response cache tag and policy engine with a byte budget.
// Input channel in_*: one transaction is a lookup (command 0) or an insert
// (command 1) with its key and record length. Output channel out_*: exactly
// one result transaction per input transaction, in order.
// A lookup scans the entry memory one entry a cycle and stops at the first
// hit. An insert runs one full scan per eviction check, one more scan on a
// full table, then picks the free slot, writes it and presents the result.
// Throughput: one transaction in flight; the next is taken only after the
// previous result has left the output register.
// Reset (rst_n low, synchronous): all entries invalid, use clock and byte
// count zero, budget back to 32 MiB. No clearing pass is needed.
// Stall: while out_ready is low the result is held; the engine waits idle
// and in_ready stays low until the result is taken.
// Configuration: register 0 (byte_budget) at address 0, written only idle
// by the user; the block itself does not enforce this.
module lru_response_cache_byte_budget #(
  parameter int unsigned ENTRIES = lrc_pkg::DEFAULT_ENTRIES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_command,
  input  wire logic [1:0]  in_key_kind,
  input  wire logic [7:0]  in_table_id,
  input  wire logic [23:0] in_archive_id,
  input  wire logic [7:0]  in_key_flags,
  input  wire logic [30:0] in_record_length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_hit,
  output logic [9:0]       out_slot,
  output logic [30:0]      out_hit_length,
  output logic             out_stored,
  output logic [10:0]      out_evicted_count,
  output logic [30:0]      out_bytes_in_use,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  logic [30:0] budget_r;
  logic        busy_r;
  logic        cmd_r, cacheable_r;
  logic [lrc_pkg::KEY_W-1:0] key_r;
  logic [30:0] len_r;
  logic        start_r;
  logic        done;
  logic        e_hit, e_stored;
  logic [9:0]  e_slot;
  logic [30:0] e_hlen, e_bytes;
  logic [10:0] e_evc;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == {lrc_pkg::REG_BUDGET, 1'b0}) ? {1'b0, budget_r} : 32'd0;
  // Accept a new transaction only when idle and the output slot is free.
  assign in_ready = !busy_r && !out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r  <= lrc_pkg::DEFAULT_BUDGET;
      busy_r    <= 1'b0;
      start_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == {lrc_pkg::REG_BUDGET, 1'b0})
        budget_r <= cfg_pwdata[30:0];
      if (in_valid && in_ready) begin
        busy_r      <= 1'b1;
        start_r     <= 1'b1;
        cmd_r       <= in_command;
        cacheable_r <= (in_key_kind == lrc_pkg::KIND_ARCHIVE) ||
                       (in_key_kind == lrc_pkg::KIND_REFTAB);
        key_r <= lrc_pkg::make_key(in_key_kind, in_table_id, in_archive_id, in_key_flags);
        len_r <= in_record_length;
      end
      if (done) begin
        busy_r            <= 1'b0;
        out_valid         <= 1'b1;
        out_hit           <= e_hit;
        out_slot          <= e_slot;
        out_hit_length    <= e_hlen;
        out_stored        <= e_stored;
        out_evicted_count <= e_evc;
        out_bytes_in_use  <= e_bytes;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  lrc_engine #(.ENTRIES(ENTRIES)) u_engine (
    .clk, .rst_n, .start(start_r), .cmd(cmd_r), .cacheable(cacheable_r),
    .key(key_r), .len(len_r), .budget(budget_r), .done,
    .r_hit(e_hit), .r_slot(e_slot), .r_hit_len(e_hlen), .r_stored(e_stored),
    .r_evicted(e_evc), .r_bytes(e_bytes)
  );
endmodule
`default_nettype wire

// File: src/lrc_engine.sv
`default_nettype none
// Scan sequencer over the entry memories. One memory entry is read per cycle
// (registered read data), compared, and the chosen entry is rewritten after
// the scan. Valid bits sit in flip-flops cleared at reset.
module lrc_engine #(
  parameter int unsigned ENTRIES = lrc_pkg::DEFAULT_ENTRIES
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic                     cmd,
  input  wire logic                     cacheable,
  input  wire logic [lrc_pkg::KEY_W-1:0] key,
  input  wire logic [lrc_pkg::LEN_W-1:0] len,
  input  wire logic [30:0]              budget,
  output logic                          done,
  output logic                          r_hit,
  output logic [lrc_pkg::SLOT_W-1:0]    r_slot,
  output logic [lrc_pkg::LEN_W-1:0]     r_hit_len,
  output logic                          r_stored,
  output logic [lrc_pkg::EVC_W-1:0]     r_evicted,
  output logic [lrc_pkg::LEN_W-1:0]     r_bytes
);
  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = IW + 1;
  localparam logic [CW-1:0] LAST = CW'(ENTRIES);

  typedef enum logic [2:0] {S_IDLE, S_LOOK, S_EVSCAN, S_EVDONE, S_FREE, S_WRITE, S_DONE}
    state_t;
  state_t state_r;

  logic [lrc_pkg::KEY_W-1:0]   key_mem   [ENTRIES];
  logic [lrc_pkg::LEN_W-1:0]   len_mem   [ENTRIES];
  logic [lrc_pkg::STAMP_W-1:0] stamp_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  logic [lrc_pkg::KEY_W-1:0]   rd_key_r;
  logic [lrc_pkg::LEN_W-1:0]   rd_len_r;
  logic [lrc_pkg::STAMP_W-1:0] rd_stamp_r;
  logic                        rd_valid_r;
  logic [IW-1:0]               rd_idx_r;
  logic                        rd_en_r;

  logic [CW-1:0] addr_r;
  logic [lrc_pkg::STAMP_W-1:0] clock_r, best_stamp_r;
  logic [IW-1:0] best_r;
  logic          found_r;
  logic [lrc_pkg::LEN_W-1:0] best_len_r;
  logic [lrc_pkg::LEN_W-1:0] bytes_r;
  logic          wr_r;
  logic [IW-1:0] wr_idx_r;
  logic          evict_extra_r;
  logic          reading;
  logic [IW-1:0] free_idx;
  logic          free_any;

  assign reading = (state_r == S_LOOK || state_r == S_EVSCAN) && addr_r < LAST;

  // Lowest free slot by priority search over the valid flops.
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IW'(i);
        free_any = 1'b1;
      end
    end
  end

  // Memory read port and stamp/write port.
  always_ff @(posedge clk) begin
    if (reading) begin
      rd_key_r   <= key_mem[addr_r[IW-1:0]];
      rd_len_r   <= len_mem[addr_r[IW-1:0]];
      rd_stamp_r <= stamp_mem[addr_r[IW-1:0]];
    end
    rd_valid_r <= valid_r[addr_r[IW-1:0]];
    rd_idx_r   <= addr_r[IW-1:0];
    if (wr_r) begin
      key_mem[wr_idx_r] <= key;
      len_mem[wr_idx_r] <= len;
    end
    if (state_r == S_LOOK && rd_en_r && rd_valid_r && rd_key_r == key && !found_r)
      stamp_mem[rd_idx_r] <= clock_r + 64'd1;
    else if (wr_r)
      stamp_mem[wr_idx_r] <= clock_r;
  end

  logic [31:0] need;
  assign need = {1'b0, bytes_r} + {1'b0, len};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      clock_r <= '0;
      bytes_r <= '0;
      rd_en_r <= 1'b0;
      wr_r    <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      wr_r <= 1'b0;
      rd_en_r <= reading;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            r_hit <= 1'b0; r_slot <= '0; r_hit_len <= '0; r_stored <= 1'b0;
            r_evicted <= '0; found_r <= 1'b0; addr_r <= '0; evict_extra_r <= 1'b0;
            if (cmd == lrc_pkg::CMD_LOOKUP) begin
              state_r <= cacheable ? S_LOOK : S_DONE;
            end else if (cacheable && len != '0 && len <= budget) begin
              state_r <= S_EVSCAN;
              found_r <= 1'b0;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_LOOK: begin
          if (addr_r < LAST) addr_r <= addr_r + CW'(1);
          if (rd_en_r && rd_valid_r && rd_key_r == key && !found_r) begin
            found_r   <= 1'b1;
            clock_r   <= clock_r + 64'd1;
            r_hit     <= 1'b1;
            r_slot    <= lrc_pkg::SLOT_W'(rd_idx_r);
            r_hit_len <= rd_len_r;
            state_r   <= S_DONE;
          end else if (!reading && !rd_en_r) begin
            state_r <= S_DONE;
          end
        end
        S_EVSCAN: begin
          // Minimum stamp search; tie keeps the lowest slot.
          if (addr_r < LAST) addr_r <= addr_r + CW'(1);
          if (rd_en_r && rd_valid_r &&
              (!found_r || rd_stamp_r < best_stamp_r)) begin
            found_r      <= 1'b1;
            best_r       <= rd_idx_r;
            best_stamp_r <= rd_stamp_r;
            best_len_r   <= rd_len_r;
          end
          if (!reading && !rd_en_r) state_r <= S_EVDONE;
        end
        S_EVDONE: begin
          // Evict the candidate if the budget or a full table requires it.
          if (found_r && (need > {1'b0, budget} || evict_extra_r)) begin
            valid_r[best_r] <= 1'b0;
            bytes_r   <= bytes_r - best_len_r;
            r_evicted <= r_evicted + lrc_pkg::EVC_W'(1);
            found_r   <= 1'b0;
            addr_r    <= '0;
            state_r   <= evict_extra_r ? S_FREE : S_EVSCAN;
          end else begin
            addr_r  <= '0;
            state_r <= S_FREE;
          end
        end
        S_FREE: begin
          if (free_any) begin
            wr_idx_r <= free_idx;
            state_r  <= S_WRITE;
          end else if (!evict_extra_r) begin
            evict_extra_r <= 1'b1;
            found_r <= 1'b0;
            addr_r  <= '0;
            state_r <= S_EVSCAN;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_WRITE: begin
          wr_r <= 1'b1;
          valid_r[wr_idx_r] <= 1'b1;
          clock_r  <= clock_r + 64'd1;
          bytes_r  <= need[30:0];
          r_stored <= 1'b1;
          r_slot   <= lrc_pkg::SLOT_W'(wr_idx_r);
          state_r  <= S_DONE;
        end
        S_DONE: begin
          if (!wr_r) begin
            done    <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign r_bytes = bytes_r;
endmodule
`default_nettype wire

// File: src/lrc_checker.sv
`default_nettype none
module lrc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_hit,
  input wire logic        out_stored,
  input wire logic [10:0] out_evicted_count
);
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_stored)) else $error("hit and stored together");
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> out_evicted_count == 11'd0) else $error("hit evicted");
  a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready) else $error("input taken while result held");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

bind lru_response_cache_byte_budget lrc_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_hit, .out_stored, .out_evicted_count
);
`default_nettype wire
